// ===== sv/nrpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node remote page translation: shared package
// Field widths, operation and status codes, page size constants and the
// layout of one entry of the region table.
// ----------------------------------------------------------------------------
package nrpt_pkg;

	// Default table and pool limits.
	localparam int MAX_REGIONS_DEF = 16;
	localparam int POOL_COUNT_DEF  = 16;

	// Page geometry: a megabyte holds this many 4 KiB pages.
	localparam int PAGE_BYTES   = 4096;
	localparam int MB_BYTES     = 1 << 20;
	localparam int PAGES_PER_MB = MB_BYTES / PAGE_BYTES;
	localparam int MB_SHIFT     = $clog2(PAGES_PER_MB);

	// Field widths.
	localparam int PAGE_W   = 32;
	localparam int MB_W     = 16;
	localparam int POOL_W   = 4;
	localparam int STATUS_W = 3;
	localparam int MODE_W   = 2;
	localparam int NPAGE_W  = MB_W + MB_SHIFT;

	// Operation codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_LOCAL  = 2'd1,
		MODE_REMOTE = 2'd2,
		MODE_XLATE  = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_POOL_SMALL = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_NO_FREE    = 3'd3,
		ST_NOT_MAPPED = 3'd4
	} status_t;

	// One region table entry.
	typedef struct packed {
		logic [PAGE_W-1:0]  node_base;
		logic [PAGE_W-1:0]  pool_base;
		logic [NPAGE_W-1:0] size_pages;
		logic [POOL_W-1:0]  pool;
	} region_t;

endpackage

// ===== sv/nrpt_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node remote page translation: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one word per operation.
interface nrpt_req_if import nrpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [PAGE_W-1:0] page;
	logic [MB_W-1:0]   region_mb;
	logic [PAGE_W-1:0] pool_base_page;
	logic [POOL_W-1:0] pool;
	logic [PAGE_W-1:0] pool_free_pages;

	modport source (output valid, mode, page, region_mb, pool_base_page, pool,
		pool_free_pages, input ready);
	modport sink (input valid, mode, page, region_mb, pool_base_page, pool,
		pool_free_pages, output ready);
endinterface

// Response channel: one word per request.
interface nrpt_rsp_if import nrpt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PAGE_W-1:0]   page_out;
	logic [POOL_W-1:0]   pool_out;
	logic                page_local;
	logic [PAGE_W-1:0]   free_count;

	modport source (output valid, status, page_out, pool_out, page_local, free_count,
		input ready);
	modport sink (input valid, status, page_out, pool_out, page_local, free_count,
		output ready);
endinterface

// Configuration channel: write of the local page count.
interface nrpt_cfg_if import nrpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== sv/node_remote_page_translation_core.sv =====
`timescale 1ns / 1ps
// Allocate and add-region words are decided in the execute state and then go to the output register.
// A translation that is not local and meets a filled table scans the entries oldest first and, on a hit,
// forms the pool page in a final state; a miss, a local page or an empty table skips that state.
// Throughput: one word at a time; the region scan reads one table entry per cycle.
// Reset clears the counters and local page count to zero; the table contents are
// not cleared and only entries below the region count are ever matched.
// ----------------------------------------------------------------------------
// Node remote page translation core
// Keeps the node page map: local pages, remote regions granted by pools and
// allocation counters. Region entries live in a synchronous table memory that
// translations scan in order.
// ----------------------------------------------------------------------------
module node_remote_page_translation_core import nrpt_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF,
	parameter int POOL_COUNT  = POOL_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nrpt_cfg_if.sink   cfg,
	nrpt_req_if.sink   req,
	nrpt_rsp_if.source rsp
);

	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FIN,
		S_OUT
	} state_t;

	state_t state_q;

	// Map state.
	logic [PAGE_W-1:0] lpc_q;
	logic [PAGE_W-1:0] total_q;
	logic [PAGE_W-1:0] remote_total_q;
	logic [PAGE_W-1:0] local_used_q;
	logic [PAGE_W-1:0] remote_used_q;
	logic [PAGE_W-1:0] free_q;
	logic [CNT_W-1:0]  region_count_q;

	// Captured request word.
	mode_t             item_mode_q;
	logic [PAGE_W-1:0] item_page_q;
	logic [MB_W-1:0]   item_mb_q;
	logic [PAGE_W-1:0] item_rbase_q;
	logic [POOL_W-1:0] item_pool_q;
	logic [PAGE_W-1:0] item_pfree_q;

	// Scan and pending result.
	logic [IDX_W-1:0]  idx_q;
	logic [PAGE_W-1:0] hit_off_q;
	logic [PAGE_W-1:0] hit_rbase_q;
	logic [POOL_W-1:0] hit_pool_q;
	status_t           res_status_q;
	logic [PAGE_W-1:0] res_page_q;
	logic [POOL_W-1:0] res_pool_q;
	logic              res_local_q;

	// Response output register.
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [PAGE_W-1:0] rsp_page_q;
	logic [POOL_W-1:0] rsp_pool_q;
	logic              rsp_local_q;
	logic [PAGE_W-1:0] rsp_free_q;

	// Table memory ports.
	logic             mem_wr_en;
	region_t          mem_wr_data;
	logic [IDX_W-1:0] mem_rd_addr;
	region_t          mem_rd_data;

	// Decoded conditions.
	logic [NPAGE_W-1:0] npages;
	logic               pool_refused;
	logic               table_full;
	logic [PAGE_W:0]    total_sum;
	logic               local_none;
	logic               remote_none;
	logic               page_is_local;
	logic [PAGE_W:0]    page_diff;
	logic               entry_hit;
	logic [CNT_W-1:0]   idx_nxt;
	logic               scan_last;
	logic               req_fire;
	logic               cfg_fire;
	logic               out_load;

	// Configuration is taken only while no word is being worked on, and wins
	// over a request offered in the same cycle.
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;

	// Region size in pages and grant checks.
	assign npages       = NPAGE_W'(item_mb_q) << MB_SHIFT;
	assign total_sum    = {1'b0, total_q} + (PAGE_W + 1)'(npages);
	assign pool_refused = (32'(item_pool_q) >= 32'(POOL_COUNT))
		|| (item_pfree_q < PAGE_W'(npages));
	assign table_full   = (region_count_q >= CNT_W'(MAX_REGIONS)) || total_sum[PAGE_W];

	// Allocation exhaustion.
	assign local_none  = (local_used_q >= lpc_q) || (free_q == '0);
	assign remote_none = (remote_used_q >= remote_total_q) || (free_q == '0);

	// Translation: local range, then compare against the entry read this cycle.
	assign page_is_local = item_page_q < lpc_q;
	assign page_diff     = {1'b0, item_page_q} - {1'b0, mem_rd_data.node_base};
	assign entry_hit     = !page_diff[PAGE_W]
		&& (page_diff[PAGE_W-1:0] < PAGE_W'(mem_rd_data.size_pages));
	assign idx_nxt       = CNT_W'(idx_q) + CNT_W'(1);
	assign scan_last     = (idx_nxt == region_count_q);

	// The output register takes a finished result when it is empty or being emptied.
	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	// Table access: new entries go in at the region count; the scan reads in order.
	// Writes and scans belong to different words, so they never overlap.
	assign mem_wr_en   = (state_q == S_EXEC) && (item_mode_q == MODE_ADD)
		&& !pool_refused && !table_full;
	assign mem_wr_data = '{node_base: total_q, pool_base: item_rbase_q,
		size_pages: npages, pool: item_pool_q};
	assign mem_rd_addr = (state_q == S_EXEC) ? '0 : idx_nxt[IDX_W-1:0];

	nrpt_region_mem #(
		.MAX_REGIONS(MAX_REGIONS),
		.IDX_W      (IDX_W)
	) u_region_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(region_count_q[IDX_W-1:0]),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// Sequencer, map state and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			lpc_q          <= '0;
			total_q        <= '0;
			remote_total_q <= '0;
			local_used_q   <= '0;
			remote_used_q  <= '0;
			free_q         <= '0;
			region_count_q <= '0;
			item_mode_q    <= MODE_ADD;
			item_page_q    <= '0;
			item_mb_q      <= '0;
			item_rbase_q   <= '0;
			item_pool_q    <= '0;
			item_pfree_q   <= '0;
			idx_q          <= '0;
			hit_off_q      <= '0;
			hit_rbase_q    <= '0;
			hit_pool_q     <= '0;
			res_status_q   <= ST_OK;
			res_page_q     <= '0;
			res_pool_q     <= '0;
			res_local_q    <= 1'b0;
			rsp_valid_q    <= 1'b0;
			rsp_status_q   <= ST_OK;
			rsp_page_q     <= '0;
			rsp_pool_q     <= '0;
			rsp_local_q    <= 1'b0;
			rsp_free_q     <= '0;
		end else begin
			// The output register loads a new result or empties once its word is taken.
			if (out_load) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= res_status_q;
				rsp_page_q   <= res_page_q;
				rsp_pool_q   <= res_pool_q;
				rsp_local_q  <= res_local_q;
				rsp_free_q   <= free_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// Writing the local page count restarts the map.
			if (cfg_fire) begin
				lpc_q          <= cfg.data;
				total_q        <= cfg.data;
				free_q         <= cfg.data;
				remote_total_q <= '0;
				local_used_q   <= '0;
				remote_used_q  <= '0;
				region_count_q <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						item_mode_q  <= mode_t'(req.mode);
						item_page_q  <= req.page;
						item_mb_q    <= req.region_mb;
						item_rbase_q <= req.pool_base_page;
						item_pool_q  <= req.pool;
						item_pfree_q <= req.pool_free_pages;
						state_q      <= S_EXEC;
					end
				end

				S_EXEC: begin
					res_status_q <= ST_OK;
					res_page_q   <= '0;
					res_pool_q   <= '0;
					res_local_q  <= 1'b0;
					state_q      <= S_OUT;
					case (item_mode_q)
						MODE_ADD: begin
							if (pool_refused) begin
								res_status_q <= ST_POOL_SMALL;
							end else if (table_full) begin
								res_status_q <= ST_TABLE_FULL;
							end else begin
								res_page_q     <= total_q;
								region_count_q <= region_count_q + CNT_W'(1);
								total_q        <= total_sum[PAGE_W-1:0];
								free_q         <= free_q + PAGE_W'(npages);
								remote_total_q <= remote_total_q + PAGE_W'(npages);
							end
						end
						MODE_LOCAL: begin
							if (local_none) begin
								res_status_q <= ST_NO_FREE;
							end else begin
								res_page_q   <= local_used_q;
								local_used_q <= local_used_q + PAGE_W'(1);
								free_q       <= free_q - PAGE_W'(1);
							end
						end
						MODE_REMOTE: begin
							if (remote_none) begin
								res_status_q <= ST_NO_FREE;
							end else begin
								res_page_q    <= lpc_q + remote_used_q;
								remote_used_q <= remote_used_q + PAGE_W'(1);
								free_q        <= free_q - PAGE_W'(1);
							end
						end
						MODE_XLATE: begin
							if (page_is_local) begin
								res_local_q <= 1'b1;
								res_page_q  <= item_page_q;
							end else if (region_count_q == '0) begin
								res_status_q <= ST_NOT_MAPPED;
							end else begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						default: begin
							res_status_q <= ST_OK;
						end
					endcase
				end

				// One table entry per cycle, oldest first; the first hit wins.
				S_SCAN: begin
					if (entry_hit) begin
						hit_off_q   <= page_diff[PAGE_W-1:0];
						hit_rbase_q <= mem_rd_data.pool_base;
						hit_pool_q  <= mem_rd_data.pool;
						state_q     <= S_FIN;
					end else if (scan_last) begin
						res_status_q <= ST_NOT_MAPPED;
						state_q      <= S_OUT;
					end else begin
						idx_q <= idx_nxt[IDX_W-1:0];
					end
				end

				// Page inside the pool: remote base plus offset, wrapping.
				S_FIN: begin
					res_page_q <= hit_rbase_q + hit_off_q;
					res_pool_q <= hit_pool_q;
					state_q    <= S_OUT;
				end

				// Hand the result to the output register once it is free.
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.page_out   = rsp_page_q;
	assign rsp.pool_out   = rsp_pool_q;
	assign rsp.page_local = rsp_local_q;
	assign rsp.free_count = rsp_free_q;

endmodule

// ===== sv/nrpt_region_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node remote page translation: region table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module nrpt_region_mem import nrpt_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF,
	parameter int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  region_t          wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output region_t          rd_data
);

	region_t mem_q [MAX_REGIONS];
	region_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data valid the cycle after the address.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/nrpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node remote page translation: port checker
// Checks the response channel of the core over time and is bound to it.
// ----------------------------------------------------------------------------
module nrpt_checker import nrpt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [PAGE_W-1:0]   page_out,
	input logic [POOL_W-1:0]   pool_out,
	input logic                page_local
);

	// A stalled response word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word withdrawn while stalled");

	// A failed operation returns no page.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> (page_out == '0) && (pool_out == '0)
			&& !page_local)
		else $error("failed operation carries a page");

	// A local translation names no pool.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && page_local |-> (status == ST_OK) && (pool_out == '0))
		else $error("local page reported with a pool");

	// Status codes stay within the defined set.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK) || (status == ST_POOL_SMALL)
			|| (status == ST_TABLE_FULL) || (status == ST_NO_FREE)
			|| (status == ST_NOT_MAPPED))
		else $error("undefined status code");

endmodule

bind node_remote_page_translation_core nrpt_checker u_nrpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.page_out  (rsp.page_out),
	.pool_out  (rsp.pool_out),
	.page_local(rsp.page_local)
);
